/* rtl/core/lpjfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpjfp_pkg: shared types and constants of the joint frame parser
// Holds the frame constants and the structs passed between the front end
// and the back end.
// ----------------------------------------------------------------------------
package lpjfp_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'h4E;
  localparam logic [3:0] RESULT_LIMIT = 4'd8;
  localparam int         LANES        = 4;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_LEN_ERR  = 1'b1;

  // One completed frame handed from the front end to the back end.
  typedef struct packed {
    logic       err;
    logic       bank;
    logic [3:0] jc;
  } job_t;

  // Back end tells the front end that a payload bank has been drained.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

/* rtl/core/lpjfp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpjfp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpjfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/lpjfp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpjfp_front: byte parser of the joint frame parser
// Hunts for the header, takes the length, writes payload bytes into the
// active bank of the payload RAM and queues one job per completed frame.
// ----------------------------------------------------------------------------
module lpjfp_front import lpjfp_pkg::*; #(
  parameter int MAX_JOINTS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             rx_byte,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cfg_write,
  input  logic [3:0]             cfg_data,
  input  logic                   q_full,
  output logic                   push,
  output job_t                   push_job,
  input  release_t               rel,
  output logic [LANES-1:0]       ram_we,
  output logic [(MAX_JOINTS > 1 ? $clog2(MAX_JOINTS) : 1):0] ram_addr,
  output logic [7:0]             ram_data
);

  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_PAY  = 3'b100
  } phase_t;

  phase_t     phase;
  logic [3:0] joint_count;
  logic [7:0] payload_len;
  logic [7:0] byte_position;
  logic       wbank;
  logic [1:0] bank_busy;
  logic [1:0] bank_busy_next;

  logic       accept;
  logic [5:0] pos_word;
  logic       stored;
  logic [7:0] pos_inc;
  logic       done;
  logic       frame_ok;

  assign in_stall = (phase == PH_PAY) && (bank_busy[wbank] || q_full);
  assign accept   = in_valid && !in_stall;

  assign pos_word = byte_position[7:2];
  assign stored   = pos_word < 6'(MAX_JOINTS);
  assign pos_inc  = byte_position + 8'd1;
  assign done     = pos_inc >= payload_len;

  // A frame is good only when the register fits storage and the result limit.
  assign frame_ok = (joint_count != 4'd0) &&
                    ({2'b00, joint_count} <= 6'(MAX_JOINTS)) &&
                    (joint_count <= RESULT_LIMIT) &&
                    (payload_len == {2'b00, joint_count, 2'b00});

  assign push          = accept && (phase == PH_PAY) && done;
  assign push_job.err  = !frame_ok;
  assign push_job.bank = wbank;
  assign push_job.jc   = joint_count;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ram_we[k] = accept && (phase == PH_PAY) && stored &&
                  (byte_position[1:0] == 2'(k));
    end
  end

  always_comb begin
    bank_busy_next = bank_busy;
    if (rel.valid) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (push && frame_ok) begin
      bank_busy_next[wbank] = 1'b1;
    end
  end

  assign ram_addr = {wbank, pos_word[JW-1:0]};
  assign ram_data = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      joint_count   <= 4'd6;
      payload_len   <= 8'd0;
      byte_position <= 8'd0;
      wbank         <= 1'b0;
      bank_busy     <= 2'b00;
    end else begin
      if (cfg_write) begin
        joint_count <= cfg_data;
      end
      bank_busy <= bank_busy_next;
      if (push && frame_ok) begin
        wbank <= !wbank;
      end
      if (accept) begin
        case (phase)
          PH_LEN: begin
            payload_len   <= rx_byte;
            byte_position <= 8'd0;
            phase         <= (rx_byte != 8'd0) ? PH_PAY : PH_HUNT;
          end
          PH_PAY: begin
            byte_position <= pos_inc;
            if (done) begin
              phase <= PH_HUNT;
            end
          end
          default: begin
            phase <= (rx_byte == HEADER_BYTE) ? PH_LEN : PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

/* rtl/core/lpjfp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpjfp_fifo: two-entry job queue
// Decouples the byte parser from the result sequencer.
// ----------------------------------------------------------------------------
module lpjfp_fifo import lpjfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = entries[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/lpjfp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpjfp_back: result sequencer of the joint frame parser
// Takes one job at a time, reads the stored joint words and presents one
// result per joint, or one length error result.
// ----------------------------------------------------------------------------
module lpjfp_back import lpjfp_pkg::*; #(
  parameter int MAX_JOINTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        rd_en,
  output logic [(MAX_JOINTS > 1 ? $clog2(MAX_JOINTS) : 1):0] rd_addr,
  input  logic [31:0] rd_data,
  output release_t    rel,
  output logic [2:0]  joint_index,
  output logic [31:0] position_bits,
  output logic        frame_status,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);

  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_SEND = 3'b100
  } bk_state_t;

  bk_state_t  state;
  job_t       cur;
  logic [2:0] idx;
  logic [2:0] idx_next;
  logic       sent;

  assign out_valid = (state == BK_SEND);
  assign sent      = (state == BK_SEND) && !out_stall;
  assign pop       = (state == BK_IDLE) && !q_empty;
  assign idx_next  = idx + 3'd1;

  assign rel.valid = sent && last && !cur.err;
  assign rel.bank  = cur.bank;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {head.bank, JW'(0)};
    case (state)
      BK_IDLE: begin
        rd_en   = pop && !head.err;
        rd_addr = {head.bank, JW'(0)};
      end
      BK_SEND: begin
        rd_en   = sent && !last;
        rd_addr = {cur.bank, JW'(idx_next)};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      case (state)
        BK_IDLE: begin
          if (pop) begin
            state <= head.err ? BK_SEND : BK_READ;
          end
        end
        BK_READ: begin
          state <= BK_SEND;
        end
        BK_SEND: begin
          if (sent) begin
            state <= last ? BK_IDLE : BK_READ;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

  // Payload registers of the current job and of the result on show.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          cur           <= head;
          idx           <= 3'd0;
          joint_index   <= 3'd0;
          position_bits <= 32'd0;
          frame_status  <= STATUS_LEN_ERR;
          last          <= 1'b1;
        end
      end
      BK_READ: begin
        joint_index   <= idx;
        position_bits <= rd_data;
        frame_status  <= STATUS_OK;
        last          <= ({1'b0, idx} + 4'd1) == cur.jc;
      end
      BK_SEND: begin
        if (sent && !last) begin
          idx <= idx_next;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

/* rtl/core/length_prefixed_joint_frame_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_joint_frame_parser_top: serial joint frame parser
// Parses header / length / payload byte frames and reports one position bit
// pattern per joint, or one length error result per bad frame.
//
// Channel  | Valid      | Stall      | Payload
// ---------+------------+------------+-----------------------------------------
// input    | in_valid   | in_stall   | rx_byte
// output   | out_valid  | out_stall  | joint_index, position_bits,
//          |            |            | frame_status, last
// config   | cfg_write  | none       | cfg_data (joint count)
//
// The parser takes one byte per cycle. A payload byte is held off while both
// payload RAM banks hold frames not yet drained, or the two-entry job queue
// is full. Each joint result of the sequencer is preceded by a registered
// RAM read in a state of its own. Reset is synchronous and needs no clearing
// pass; joint count resets to six. Output stalls only slow the sequencer
// until both banks or the job queue fill.
// ----------------------------------------------------------------------------
module length_prefixed_joint_frame_parser_top import lpjfp_pkg::*; #(
  parameter int MAX_JOINTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cfg_write,
  input  logic [3:0]  cfg_data,
  output logic [2:0]  joint_index,
  output logic [31:0] position_bits,
  output logic        frame_status,
  output logic        last,
  output logic        out_valid,
  input  logic        out_stall
);

  localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int DEPTH = 2 ** (JW + 1);

  logic              push;
  job_t              push_job;
  job_t              head;
  logic              q_empty;
  logic              q_full;
  logic              pop;
  release_t          rel;
  logic [LANES-1:0]  ram_we;
  logic [JW:0]       ram_addr;
  logic [7:0]        ram_data;
  logic              rd_en;
  logic [JW:0]       rd_addr;
  logic [31:0]       rd_data;

  lpjfp_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job),
    .rel       (rel),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_data  (ram_data)
  );

  lpjfp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // One byte lane per RAM; lane k holds bits 8k+7..8k of each joint word.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    lpjfp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk     (clk),
      .wr_en   (ram_we[k]),
      .wr_addr (ram_addr),
      .wr_data (ram_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data[8*k +: 8])
    );
  end

  lpjfp_back #(.MAX_JOINTS(MAX_JOINTS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .rel           (rel),
    .joint_index   (joint_index),
    .position_bits (position_bits),
    .frame_status  (frame_status),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule
